FILE: rtl/core/ajd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ajd_pkg;

  localparam int AXIS_BITS_DEFAULT = 16;
  localparam int BUTTON_BITS       = 16;
  localparam int COUNT_BITS        = 5;
  localparam int DIR_BITS          = 10;
  localparam logic [COUNT_BITS-1:0] MAX_BUTTONS       = 5'd16;
  localparam logic [COUNT_BITS-1:0] BUTTON_COUNT_INIT = 5'd16;

  // Bit positions in the direction word
  localparam int DIR_DOWN_BIT  = 0;
  localparam int DIR_RIGHT_BIT = 1;
  localparam int DIR_UP_BIT    = 8;
  localparam int DIR_LEFT_BIT  = 9;

  typedef struct packed {
    logic low_third;
    logic high_third;
  } axis_class_t;

endpackage
`default_nettype wire

FILE: rtl/core/ajd_axis_class.sv
`timescale 1ns / 1ps
`default_nettype none
module ajd_axis_class #(
  parameter int AXIS_BITS = ajd_pkg::AXIS_BITS_DEFAULT
) (
  input  wire logic signed [AXIS_BITS-1:0] reading,
  input  wire logic signed [AXIS_BITS-1:0] low_seen,
  input  wire logic signed [AXIS_BITS-1:0] high_seen,
  output ajd_pkg::axis_class_t             cls
);
  import ajd_pkg::*;

  localparam int W = AXIS_BITS + 1;

  logic signed [W-1:0] offs_s;
  logic signed [W-1:0] span_s;
  logic [W-1:0]   offs;
  logic [W-1:0]   span;
  logic [W+1:0]   offs3;
  logic [W+1:0]   offs3_p3;
  logic [W+1:0]   span_x1;
  logic [W+1:0]   span_x2;

  // reading >= low_seen and high_seen >= low_seen, so both differences are nonnegative
  assign offs_s = W'(reading) - W'(low_seen);
  assign span_s = W'(high_seen) - W'(low_seen);
  assign offs   = offs_s;
  assign span   = span_s;

  assign offs3    = {1'b0, offs, 1'b0} + {2'b00, offs};
  assign offs3_p3 = offs3 + (W+2)'(3);
  assign span_x1  = {2'b00, span};
  assign span_x2  = {1'b0, span, 1'b0};

  // offs < floor(span/3)    <=> 3*(offs+1) <= span
  // offs > floor(2*span/3)  <=> 3*offs > 2*span
  assign cls.low_third  = offs3_p3 <= span_x1;
  assign cls.high_third = !cls.low_third && (offs3 > span_x2);

endmodule
`default_nettype wire

FILE: rtl/core/analog_joystick_to_digital_direction_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake            Payload
// input     in_valid / in_stall  stick_select, x_reading, y_reading, raw_buttons
// output    out_valid/ out_stall direction_word, button_mask
// config    cfg_we               cfg_data (button_count)
//
// Two register levels: the range update happens as an item enters the middle stage;
// the classification lands in the output register when it is free. One item per
// cycle while out_stall is low; the per-stick min/max update is the only loop.
// Reset (rst, synchronous) collapses both ranges to empty and sets button_count to 16.
// in_stall rises only when both the stage and the output register hold items.
module analog_joystick_to_digital_direction_top #(
  parameter int AXIS_BITS = ajd_pkg::AXIS_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [ajd_pkg::COUNT_BITS-1:0]      cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                stick_select,
  input  wire logic signed [AXIS_BITS-1:0]         x_reading,
  input  wire logic signed [AXIS_BITS-1:0]         y_reading,
  input  wire logic [ajd_pkg::BUTTON_BITS-1:0]     raw_buttons,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [ajd_pkg::DIR_BITS-1:0]             direction_word,
  output logic [ajd_pkg::BUTTON_BITS-1:0]          button_mask
);
  import ajd_pkg::*;

  localparam logic signed [AXIS_BITS-1:0] AXIS_MAX = {1'b0, {(AXIS_BITS-1){1'b1}}};
  localparam logic signed [AXIS_BITS-1:0] AXIS_MIN = {1'b1, {(AXIS_BITS-1){1'b0}}};

  logic [COUNT_BITS-1:0] button_count;

  logic signed [AXIS_BITS-1:0] x_low_seen  [2];
  logic signed [AXIS_BITS-1:0] x_high_seen [2];
  logic signed [AXIS_BITS-1:0] y_low_seen  [2];
  logic signed [AXIS_BITS-1:0] y_high_seen [2];

  logic signed [AXIS_BITS-1:0] x_low_next, x_high_next, y_low_next, y_high_next;

  // middle stage
  logic                        mid_valid;
  logic signed [AXIS_BITS-1:0] mid_x, mid_x_low, mid_x_high;
  logic signed [AXIS_BITS-1:0] mid_y, mid_y_low, mid_y_high;
  logic [BUTTON_BITS-1:0]      mid_buttons;

  logic in_take;
  logic mid_advance;
  logic out_free;

  logic [COUNT_BITS-1:0]  eff_count;
  logic [BUTTON_BITS-1:0] mask_next;

  axis_class_t x_cls, y_cls;
  logic [DIR_BITS-1:0] dir_next;

  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = mid_valid && !out_free;
  assign in_take     = in_valid && !in_stall;
  assign mid_advance = mid_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_count <= BUTTON_COUNT_INIT;
    end else if (cfg_we) begin
      button_count <= cfg_data;
    end
  end

  // widen the selected stick's range with the sample
  always_comb begin
    x_low_next  = x_low_seen[stick_select];
    x_high_next = x_high_seen[stick_select];
    y_low_next  = y_low_seen[stick_select];
    y_high_next = y_high_seen[stick_select];
    if (x_reading < x_low_next)  x_low_next  = x_reading;
    if (x_reading > x_high_next) x_high_next = x_reading;
    if (y_reading < y_low_next)  y_low_next  = y_reading;
    if (y_reading > y_high_next) y_high_next = y_reading;
  end

  always_comb begin
    eff_count = (button_count > MAX_BUTTONS) ? MAX_BUTTONS : button_count;
    for (int i = 0; i < BUTTON_BITS; i++) begin
      mask_next[i] = raw_buttons[i] && (COUNT_BITS'(i) < eff_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        x_low_seen[i]  <= AXIS_MAX;
        x_high_seen[i] <= AXIS_MIN;
        y_low_seen[i]  <= AXIS_MAX;
        y_high_seen[i] <= AXIS_MIN;
      end
    end else if (in_take) begin
      x_low_seen[stick_select]  <= x_low_next;
      x_high_seen[stick_select] <= x_high_next;
      y_low_seen[stick_select]  <= y_low_next;
      y_high_seen[stick_select] <= y_high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_take) begin
      mid_valid <= 1'b1;
    end else if (mid_advance) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mid_x       <= x_reading;
      mid_x_low   <= x_low_next;
      mid_x_high  <= x_high_next;
      mid_y       <= y_reading;
      mid_y_low   <= y_low_next;
      mid_y_high  <= y_high_next;
      mid_buttons <= mask_next;
    end
  end

  ajd_axis_class #(.AXIS_BITS(AXIS_BITS)) u_x_class (
    .reading   (mid_x),
    .low_seen  (mid_x_low),
    .high_seen (mid_x_high),
    .cls       (x_cls)
  );

  ajd_axis_class #(.AXIS_BITS(AXIS_BITS)) u_y_class (
    .reading   (mid_y),
    .low_seen  (mid_y_low),
    .high_seen (mid_y_high),
    .cls       (y_cls)
  );

  // pack: up folds in left, down folds in right
  always_comb begin
    dir_next                = '0;
    dir_next[DIR_LEFT_BIT]  = x_cls.low_third;
    dir_next[DIR_RIGHT_BIT] = x_cls.high_third;
    dir_next[DIR_UP_BIT]    = y_cls.low_third ^ x_cls.low_third;
    dir_next[DIR_DOWN_BIT]  = y_cls.high_third ^ x_cls.high_third;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_advance) begin
      direction_word <= dir_next;
      button_mask    <= mid_buttons;
    end
  end

endmodule
`default_nettype wire

FILE: tb/joystick_direction_checker.sv
`timescale 1ns / 1ps
module joystick_direction_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ajd_pkg::COUNT_BITS-1:0]    cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              stick_select,
  input  logic signed [15:0]                x_reading,
  input  logic signed [15:0]                y_reading,
  input  logic [ajd_pkg::BUTTON_BITS-1:0]   raw_buttons,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [ajd_pkg::DIR_BITS-1:0]      direction_word,
  input  logic [ajd_pkg::BUTTON_BITS-1:0]   button_mask,
  output int                                mismatches,
  output int                                pending
);
  import ajd_pkg::*;

  localparam int AXIS_TOP    = 32767;
  localparam int AXIS_BOTTOM = -32768;

  typedef struct packed {
    logic [DIR_BITS-1:0]    dir;
    logic [BUTTON_BITS-1:0] mask;
  } joy_result_t;

  int                  x_lo [2];
  int                  x_hi [2];
  int                  y_lo [2];
  int                  y_hi [2];
  logic [COUNT_BITS-1:0] button_count;
  joy_result_t         expected_words [$];
  joy_result_t         want;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // -1 for the low third of the span, +1 for the high third, 0 in between
  function automatic int axis_side(input int v, input int lo, input int hi);
    int span;
    span = hi - lo;
    if (v < lo + span / 3) return -1;
    if (v > lo + (2 * span) / 3) return 1;
    return 0;
  endfunction

  function automatic joy_result_t predict_direction(input logic s, input int x, input int y,
                                                    input logic [BUTTON_BITS-1:0] raw);
    joy_result_t res;
    int          cx;
    int          cy;
    int          n;
    logic [31:0] keep;
    logic        left;
    logic        right;
    logic        up;
    logic        down;
    // widen the range first, then classify against it
    if (x < x_lo[s]) x_lo[s] = x;
    if (x > x_hi[s]) x_hi[s] = x;
    if (y < y_lo[s]) y_lo[s] = y;
    if (y > y_hi[s]) y_hi[s] = y;
    cx = axis_side(x, x_lo[s], x_hi[s]);
    cy = axis_side(y, y_lo[s], y_hi[s]);
    left  = (cx < 0);
    right = (cx > 0);
    up    = (cy < 0) ^ left;
    down  = (cy > 0) ^ right;
    res.dir = '0;
    res.dir[DIR_DOWN_BIT]  = down;
    res.dir[DIR_RIGHT_BIT] = right;
    res.dir[DIR_UP_BIT]    = up;
    res.dir[DIR_LEFT_BIT]  = left;
    n = (button_count > MAX_BUTTONS) ? int'(MAX_BUTTONS) : int'(button_count);
    keep = (32'd1 << n) - 32'd1;
    res.mask = raw & keep[BUTTON_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        x_lo[i] = AXIS_TOP;
        x_hi[i] = AXIS_BOTTOM;
        y_lo[i] = AXIS_TOP;
        y_hi[i] = AXIS_BOTTOM;
      end
      button_count = BUTTON_COUNT_INIT;
      expected_words.delete();
      pending = 0;
    end else begin
      if (cfg_we) button_count = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result with no sample pending: direction_word %h button_mask %h",
                 direction_word, button_mask);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (direction_word !== want.dir) begin
            $error("direction_word mismatch: expected %h, got %h", want.dir, direction_word);
            mismatches++;
          end
          if (button_mask !== want.mask) begin
            $error("button_mask mismatch: expected %h, got %h", want.mask, button_mask);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_words.push_back(predict_direction(stick_select, int'(x_reading),
                                                   int'(y_reading), raw_buttons));
      pending = expected_words.size();
    end
  end

endmodule

FILE: tb/analog_joystick_to_digital_direction_top_tb.sv
`timescale 1ns / 1ps
module analog_joystick_to_digital_direction_top_tb;
  import ajd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 60;
  // thresholds of the full 16-bit span: below LOW is left/up, above HIGH is right/down
  localparam int THIRD_LOW   = -10923;
  localparam int THIRD_HIGH  = 10922;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [COUNT_BITS-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   stick_select = 1'b0;
  logic signed [15:0]     x_reading = '0;
  logic signed [15:0]     y_reading = '0;
  logic [BUTTON_BITS-1:0] raw_buttons = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DIR_BITS-1:0]    direction_word;
  logic [BUTTON_BITS-1:0] button_mask;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int samples_sent = 0;
  int settings_used = 1;
  int hold_requests = 0;
  int holds_done = 0;
  bit bursty = 1'b1;

  always #1 clk = ~clk;

  analog_joystick_to_digital_direction_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .stick_select   (stick_select),
    .x_reading      (x_reading),
    .y_reading      (y_reading),
    .raw_buttons    (raw_buttons),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .direction_word (direction_word),
    .button_mask    (button_mask)
  );

  joystick_direction_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .stick_select   (stick_select),
    .x_reading      (x_reading),
    .y_reading      (y_reading),
    .raw_buttons    (raw_buttons),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .direction_word (direction_word),
    .button_mask    (button_mask),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("analog_joystick_to_digital_direction_top test failed");
      $finish;
    end
  end

  // Offer one item; return at the falling edge after it is accepted.
  task automatic send_sample(input int s, input int x, input int y, input int b);
    int gap;
    gap = bursty ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    stick_select = s[0];
    x_reading    = x[15:0];
    y_reading    = y[15:0];
    raw_buttons  = b[15:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic set_button_count(input int value);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    // let the output register drain before touching the count
    repeat (4) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value[COUNT_BITS-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Stick 0 sees the full span: extremes, threshold neighbors, anything.
  function automatic int pick_wide();
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 1) ? 32767 : -32768;
      1: v = $urandom_range(0, 1) ? THIRD_LOW - int'($urandom_range(0, 1))
                                  : THIRD_HIGH + int'($urandom_range(0, 1));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Stick 1 sees a window that grows over the run, so its range calibrates slowly.
  function automatic int pick_narrow(input int half_width);
    return int'($urandom_range(0, 2 * half_width)) - half_width;
  endfunction

  // Output side: a random stall before each item while bursty, plus a long hold on request.
  initial begin
    int wait_cycles;
    wait (rst == 1'b0);
    forever begin
      if (holds_done != hold_requests) begin
        wait_cycles = LONG_HOLD;
        holds_done++;
      end else begin
        wait_cycles = bursty ? $urandom_range(0, 3) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int seg;
    int k;
    int s;
    int hw;
    int counts [7];
    counts = '{16, 0, 31, 1, 15, 17, 0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset count of 16; the first item on each stick lands on a collapsed range
    send_sample(0, 0, 0, 'hFFFF);
    send_sample(0, 32767, -32768, 'h8001);
    send_sample(0, -32768, 32767, 'h5555);
    send_sample(0, THIRD_LOW, THIRD_LOW - 1, 'hAAAA);
    send_sample(0, THIRD_HIGH, THIRD_HIGH + 1, 'h1234);
    send_sample(0, THIRD_LOW - 1, THIRD_HIGH, 'h0000);
    send_sample(0, THIRD_HIGH + 1, THIRD_LOW, 'h8000);
    send_sample(1, 5, -5, 'h0001);
    send_sample(1, 8, -8, 'h7FFF);
    send_sample(1, 2, 2, 'hFFFE);
    send_sample(1, 5, 5, 'h00FF);

    set_button_count(0);
    send_sample(0, 0, 0, 'hFFFF);
    send_sample(1, 6, -7, 'hFFFF);
    set_button_count(31);
    send_sample(0, -1, 1, 'hFFFF);
    send_sample(1, -3, 9, 'hFFFF);
    set_button_count(1);
    send_sample(0, 32767, 32767, 'hFFFF);
    send_sample(1, -8, -8, 'hFFFE);

    counts[6] = $urandom_range(0, 31);
    for (seg = 0; seg < 7; seg++) begin
      set_button_count(counts[seg]);
      for (k = 0; k < 260; k++) begin
        if (k % 40 == 0) bursty = ($urandom_range(0, 3) != 0);
        // long output hold while the input keeps offering
        if ((seg == 2 || seg == 5) && k == 100) hold_requests++;
        s = $urandom_range(0, 1);
        if (s == 0) begin
          send_sample(0, pick_wide(), pick_wide(), $urandom);
        end else begin
          hw = 2 + (seg * 260 + k) * 20;
          if (hw > 32767) hw = 32767;
          send_sample(1, pick_narrow(hw), pick_narrow(hw), $urandom);
        end
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d samples on both sticks under %0d button-count settings (0..31).",
             samples_sent, settings_used);
    $display("Input gaps and output stalls were random, with %0d long output holds.",
             hold_requests);
    if (mismatches == 0 && pending == 0) begin
      $display("analog_joystick_to_digital_direction_top test passed");
    end else begin
      $display("analog_joystick_to_digital_direction_top test failed");
    end
    $finish;
  end

endmodule
